// ----- hw/rtl/rvdec_pkg.sv -----
// Shared types and codes for the RV32I instruction decoder.
`default_nettype none

package rvdec_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned RegIdxWidth = 5;

  typedef enum logic [2:0] {
    FMT_R = 3'd0,
    FMT_I = 3'd1,
    FMT_S = 3'd2,
    FMT_B = 3'd3,
    FMT_U = 3'd4,
    FMT_J = 3'd5
  } fmt_e;

  typedef enum logic [5:0] {
    OP_LUI   = 6'd0,  OP_AUIPC = 6'd1,  OP_JAL   = 6'd2,  OP_JALR  = 6'd3,
    OP_BEQ   = 6'd4,  OP_BNE   = 6'd5,  OP_BLT   = 6'd6,  OP_BGE   = 6'd7,
    OP_BLTU  = 6'd8,  OP_BGEU  = 6'd9,  OP_LB    = 6'd10, OP_LH    = 6'd11,
    OP_LW    = 6'd12, OP_LBU   = 6'd13, OP_LHU   = 6'd14, OP_SB    = 6'd15,
    OP_SH    = 6'd16, OP_SW    = 6'd17, OP_ADDI  = 6'd18, OP_SLTI  = 6'd19,
    OP_SLTIU = 6'd20, OP_XORI  = 6'd21, OP_ORI   = 6'd22, OP_ANDI  = 6'd23,
    OP_SLLI  = 6'd24, OP_SRLI  = 6'd25, OP_SRAI  = 6'd26, OP_ADD   = 6'd27,
    OP_SUB   = 6'd28, OP_SLL   = 6'd29, OP_SLT   = 6'd30, OP_SLTU  = 6'd31,
    OP_XOR   = 6'd32, OP_SRL   = 6'd33, OP_SRA   = 6'd34, OP_OR    = 6'd35,
    OP_AND   = 6'd36
  } op_e;

  // Major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // Packed so that the format sits in the lowest bits of the output tdata
  typedef struct packed {
    logic [31:0]            imm_value;
    logic [RegIdxWidth-1:0] dest_index;
    logic [RegIdxWidth-1:0] src2_index;
    logic [RegIdxWidth-1:0] src1_index;
    op_e                    operation;
    fmt_e                   format_class;
  } dec_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rv32i_instruction_decoder.sv -----
// RV32I instruction decoder: stream in raw words, stream out decoded fields.
//
// One instruction word per transaction in; one decoded result per transaction out, in order.
// The word is captured in an input register, decoded by shallow logic (opcode and funct3
// selection, immediate assembly) and captured in the result register, which then offers the
// result; a new word is taken every cycle while the output side keeps up.
// Both registers stall in place under back-pressure. Unknown opcodes and unlisted funct3
// values give tuser = 1 with all tdata fields zero.
`default_nettype none

module rv32i_instruction_decoder (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [rvdec_pkg::InstrWidth-1:0]    s_axis_tdata_i,  // [31:0] instr_word
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [2:0] format_class, [8:3] operation, [13:9] src1_index, [18:14] src2_index,
  // [23:19] dest_index, [55:24] imm_value
  output logic [55:0]                              m_axis_tdata_o,
  output logic                                     m_axis_tuser_o   // [0] illegal
);
  import rvdec_pkg::*;

  logic                  in_vld_q, in_vld_d;
  logic [InstrWidth-1:0] word_q;
  logic                  out_vld_q, out_vld_d;
  dec_res_t              res_q, res_d;
  logic                  ill_q, ill_d;
  logic                  out_rdy, in_rdy;

  logic [6:0] opcode;
  logic [2:0] f3;
  logic       f7_nz;

  assign out_rdy = !out_vld_q || m_axis_tready_i;
  assign in_rdy  = !in_vld_q || out_rdy;
  assign s_axis_tready_o = in_rdy;

  assign in_vld_d  = in_rdy ? s_axis_tvalid_i : in_vld_q;
  assign out_vld_d = out_rdy ? in_vld_q : out_vld_q;

  assign opcode = word_q[6:0];
  assign f3     = word_q[14:12];
  assign f7_nz  = |word_q[31:25];

  always_comb begin
    dec_res_t r;
    logic     bad;
    r   = '0;
    bad = 1'b0;
    unique case (opcode) inside
      OPC_LUI, OPC_AUIPC: begin
        r.format_class = FMT_U;
        r.operation    = (opcode == OPC_LUI) ? OP_LUI : OP_AUIPC;
        r.dest_index   = word_q[11:7];
        r.imm_value    = {word_q[31:12], 12'b0};
      end
      OPC_JAL: begin
        r.format_class = FMT_J;
        r.operation    = OP_JAL;
        r.dest_index   = word_q[11:7];
        r.imm_value    = {{11{word_q[31]}}, word_q[31], word_q[19:12], word_q[20],
                          word_q[30:21], 1'b0};
      end
      OPC_JALR, OPC_LOAD, OPC_OP_IMM: begin
        r.format_class = FMT_I;
        r.src1_index   = word_q[19:15];
        r.dest_index   = word_q[11:7];
        r.imm_value    = {{20{word_q[31]}}, word_q[31:20]};
        if (opcode == OPC_JALR) begin
          r.operation = OP_JALR;
        end else if (opcode == OPC_LOAD) begin
          unique case (f3)
            3'd0: r.operation = OP_LB;
            3'd1: r.operation = OP_LH;
            3'd2: r.operation = OP_LW;
            3'd4: r.operation = OP_LBU;
            3'd5: r.operation = OP_LHU;
            default: bad = 1'b1;
          endcase
        end else begin
          unique case (f3)
            3'd0: r.operation = OP_ADDI;
            3'd1: r.operation = OP_SLLI;
            3'd2: r.operation = OP_SLTI;
            3'd3: r.operation = OP_SLTIU;
            3'd4: r.operation = OP_XORI;
            3'd5: r.operation = f7_nz ? OP_SRAI : OP_SRLI;
            3'd6: r.operation = OP_ORI;
            default: r.operation = OP_ANDI;
          endcase
        end
      end
      OPC_BRANCH: begin
        r.format_class = FMT_B;
        r.src1_index   = word_q[19:15];
        r.src2_index   = word_q[24:20];
        r.imm_value    = {{19{word_q[31]}}, word_q[31], word_q[7], word_q[30:25],
                          word_q[11:8], 1'b0};
        unique case (f3)
          3'd0: r.operation = OP_BEQ;
          3'd1: r.operation = OP_BNE;
          3'd4: r.operation = OP_BLT;
          3'd5: r.operation = OP_BGE;
          3'd6: r.operation = OP_BLTU;
          3'd7: r.operation = OP_BGEU;
          default: bad = 1'b1;
        endcase
      end
      OPC_STORE: begin
        r.format_class = FMT_S;
        r.src1_index   = word_q[19:15];
        r.src2_index   = word_q[24:20];
        r.imm_value    = {{20{word_q[31]}}, word_q[31:25], word_q[11:7]};
        unique case (f3)
          3'd0: r.operation = OP_SB;
          3'd1: r.operation = OP_SH;
          3'd2: r.operation = OP_SW;
          default: bad = 1'b1;
        endcase
      end
      OPC_OP: begin
        r.format_class = FMT_R;
        r.src1_index   = word_q[19:15];
        r.src2_index   = word_q[24:20];
        r.dest_index   = word_q[11:7];
        unique case (f3)
          3'd0: r.operation = f7_nz ? OP_SUB : OP_ADD;
          3'd1: r.operation = OP_SLL;
          3'd2: r.operation = OP_SLT;
          3'd3: r.operation = OP_SLTU;
          3'd4: r.operation = OP_XOR;
          3'd5: r.operation = f7_nz ? OP_SRA : OP_SRL;
          3'd6: r.operation = OP_OR;
          default: r.operation = OP_AND;
        endcase
      end
      default: bad = 1'b1;
    endcase
    // illegal words report every field as zero
    res_d = bad ? dec_res_t'('0) : r;
    ill_d = bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy) begin
      word_q <= s_axis_tdata_i;
    end
    if (out_rdy) begin
      res_q <= res_d;
      ill_q <= ill_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = ill_q;

  // An accepted word always lands in the input register
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> in_vld_q)
    else $error("accepted transaction not captured");

  // A decoded word in the input register moves on or is held, never dropped
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_rdy) |=> (in_vld_q && $stable(word_q)))
    else $error("stalled instruction word lost");

  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("illegal result with nonzero fields");

  a_op_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |->
      (res_q.operation <= OP_AND && res_q.format_class <= FMT_J))
    else $error("operation or format out of range");

  a_r_imm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o && res_q.format_class == FMT_R) |->
      (res_q.imm_value == '0))
    else $error("R-format result carries an immediate");

endmodule

`default_nettype wire

// ----- bench/tb_rv32i_instruction_decoder.sv -----
// Self-checking stream testbench for the RV32I instruction decoder.
`timescale 1ns / 100ps

module tb_rv32i_instruction_decoder;
  import rvdec_pkg::*;

  // funct3 encodings, shared by the groups that use them
  localparam logic [2:0] F3_EQ = 3'd0, F3_NE = 3'd1, F3_LT = 3'd4, F3_GE = 3'd5;
  localparam logic [2:0] F3_LTU = 3'd6, F3_GEU = 3'd7;
  localparam logic [2:0] F3_BYTE = 3'd0, F3_HALF = 3'd1, F3_WORD = 3'd2;
  localparam logic [2:0] F3_BYTE_U = 3'd4, F3_HALF_U = 3'd5;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;

  localparam int unsigned RandomItems = 1000;

  typedef struct packed {
    fmt_e        fmt;
    op_e         op;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic        illegal;
  } decoded_t;

  typedef struct packed {
    logic [31:0] word;
    decoded_t    res;
  } decode_job_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  decode_job_t awaited_q[$];
  decode_job_t head;
  logic [31:0] dir_word[$];
  bit          dir_typed[$];
  decoded_t    dir_want[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;

  rv32i_instruction_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic decoded_t make_dec(input fmt_e f, input op_e o, input logic [4:0] s1,
                                        input logic [4:0] s2, input logic [4:0] d,
                                        input logic [31:0] imm, input logic ill);
    decoded_t r;
    r.fmt = f; r.op = o; r.rs1 = s1; r.rs2 = s2; r.rd = d; r.imm = imm; r.illegal = ill;
    return r;
  endfunction

  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t   r;
    logic       known;
    logic [2:0] f3;
    logic       f7_set;
    r = '0;
    known = 1'b1;
    f3 = w[14:12];
    f7_set = |w[31:25];
    case (w[6:0]) inside
      OPC_LUI, OPC_AUIPC: begin
        r.fmt = FMT_U;
        r.op = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
        r.rd = w[11:7];
        r.imm = {w[31:12], 12'b0};
      end
      OPC_JAL: begin
        r.fmt = FMT_J;
        r.op = OP_JAL;
        r.rd = w[11:7];
        r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR, OPC_LOAD, OPC_OP_IMM: begin
        r.fmt = FMT_I;
        r.rs1 = w[19:15];
        r.rd = w[11:7];
        r.imm = {{20{w[31]}}, w[31:20]};
        if (w[6:0] == OPC_JALR) begin
          r.op = OP_JALR;
        end else if (w[6:0] == OPC_LOAD) begin
          case (f3)
            F3_BYTE:   r.op = OP_LB;
            F3_HALF:   r.op = OP_LH;
            F3_WORD:   r.op = OP_LW;
            F3_BYTE_U: r.op = OP_LBU;
            F3_HALF_U: r.op = OP_LHU;
            default:   known = 1'b0;
          endcase
        end else begin
          case (f3)
            F3_ADD:  r.op = OP_ADDI;
            F3_SLL:  r.op = OP_SLLI;
            F3_SLT:  r.op = OP_SLTI;
            F3_SLTU: r.op = OP_SLTIU;
            F3_XOR:  r.op = OP_XORI;
            F3_SR:   r.op = f7_set ? OP_SRAI : OP_SRLI;
            F3_OR:   r.op = OP_ORI;
            default: r.op = OP_ANDI;
          endcase
        end
      end
      OPC_BRANCH: begin
        r.fmt = FMT_B;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_EQ:   r.op = OP_BEQ;
          F3_NE:   r.op = OP_BNE;
          F3_LT:   r.op = OP_BLT;
          F3_GE:   r.op = OP_BGE;
          F3_LTU:  r.op = OP_BLTU;
          F3_GEU:  r.op = OP_BGEU;
          default: known = 1'b0;
        endcase
      end
      OPC_STORE: begin
        r.fmt = FMT_S;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_BYTE: r.op = OP_SB;
          F3_HALF: r.op = OP_SH;
          F3_WORD: r.op = OP_SW;
          default: known = 1'b0;
        endcase
      end
      OPC_OP: begin
        r.fmt = FMT_R;
        r.rs1 = w[19:15];
        r.rs2 = w[24:20];
        r.rd = w[11:7];
        case (f3)
          F3_ADD:  r.op = f7_set ? OP_SUB : OP_ADD;
          F3_SLL:  r.op = OP_SLL;
          F3_SLT:  r.op = OP_SLT;
          F3_SLTU: r.op = OP_SLTU;
          F3_XOR:  r.op = OP_XOR;
          F3_SR:   r.op = f7_set ? OP_SRA : OP_SRL;
          F3_OR:   r.op = OP_OR;
          default: r.op = OP_AND;
        endcase
      end
      default: known = 1'b0;
    endcase
    if (!known) begin
      r = '0;
      r.illegal = 1'b1;
    end
    return r;
  endfunction

  // Builds a well-formed word for op; bits the decoder ignores keep the random fill
  function automatic logic [31:0] encode_op(input op_e op, input logic [31:0] fill);
    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  alt7;
    w = fill;
    f3 = w[14:12];
    opc = OPC_OP;
    alt7 = ($urandom_range(1) != 0) ? 7'h20 : 7'($urandom_range(127, 1));
    case (op)
      OP_LUI:   opc = OPC_LUI;
      OP_AUIPC: opc = OPC_AUIPC;
      OP_JAL:   opc = OPC_JAL;
      OP_JALR:  opc = OPC_JALR;
      OP_BEQ:   begin opc = OPC_BRANCH; f3 = F3_EQ;  end
      OP_BNE:   begin opc = OPC_BRANCH; f3 = F3_NE;  end
      OP_BLT:   begin opc = OPC_BRANCH; f3 = F3_LT;  end
      OP_BGE:   begin opc = OPC_BRANCH; f3 = F3_GE;  end
      OP_BLTU:  begin opc = OPC_BRANCH; f3 = F3_LTU; end
      OP_BGEU:  begin opc = OPC_BRANCH; f3 = F3_GEU; end
      OP_LB:    begin opc = OPC_LOAD; f3 = F3_BYTE;   end
      OP_LH:    begin opc = OPC_LOAD; f3 = F3_HALF;   end
      OP_LW:    begin opc = OPC_LOAD; f3 = F3_WORD;   end
      OP_LBU:   begin opc = OPC_LOAD; f3 = F3_BYTE_U; end
      OP_LHU:   begin opc = OPC_LOAD; f3 = F3_HALF_U; end
      OP_SB:    begin opc = OPC_STORE; f3 = F3_BYTE; end
      OP_SH:    begin opc = OPC_STORE; f3 = F3_HALF; end
      OP_SW:    begin opc = OPC_STORE; f3 = F3_WORD; end
      OP_ADDI:  begin opc = OPC_OP_IMM; f3 = F3_ADD;  end
      OP_SLTI:  begin opc = OPC_OP_IMM; f3 = F3_SLT;  end
      OP_SLTIU: begin opc = OPC_OP_IMM; f3 = F3_SLTU; end
      OP_XORI:  begin opc = OPC_OP_IMM; f3 = F3_XOR;  end
      OP_ORI:   begin opc = OPC_OP_IMM; f3 = F3_OR;   end
      OP_ANDI:  begin opc = OPC_OP_IMM; f3 = F3_AND;  end
      OP_SLLI:  begin opc = OPC_OP_IMM; f3 = F3_SLL;  end
      OP_SRLI:  begin opc = OPC_OP_IMM; f3 = F3_SR; w[31:25] = '0;   end
      OP_SRAI:  begin opc = OPC_OP_IMM; f3 = F3_SR; w[31:25] = alt7; end
      OP_ADD:   begin f3 = F3_ADD; w[31:25] = '0;   end
      OP_SUB:   begin f3 = F3_ADD; w[31:25] = alt7; end
      OP_SLL:   f3 = F3_SLL;
      OP_SLT:   f3 = F3_SLT;
      OP_SLTU:  f3 = F3_SLTU;
      OP_XOR:   f3 = F3_XOR;
      OP_SRL:   begin f3 = F3_SR; w[31:25] = '0;   end
      OP_SRA:   begin f3 = F3_SR; w[31:25] = alt7; end
      OP_OR:    f3 = F3_OR;
      default:  f3 = F3_AND;
    endcase
    w[6:0] = opc;
    w[14:12] = f3;
    return w;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] word,
                               input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s (word %h): got %h, want %h", what, word, got, want);
    mismatches++;
  endtask

  task automatic add_row(input logic [31:0] word, input bit typed, input decoded_t want);
    dir_word.insert(dir_word.size(), word);
    dir_typed.insert(dir_typed.size(), typed);
    dir_want.insert(dir_want.size(), want);
  endtask

  task automatic send_word(input logic [31:0] word, input bit typed, input decoded_t want);
    decode_job_t job;
    job.word = word;
    job.res = typed ? want : decode_word(word);
    while (!calm && $urandom_range(99) < 38) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    awaited_q.insert(awaited_q.size(), job);
  endtask

  // Result side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= calm || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, m_axis_tdata_o[31:0], '0);
      end else begin
        head = awaited_q.pop_front();
        if (m_axis_tdata_o[2:0] !== head.res.fmt)
          note_mismatch("format_class", head.word, 32'(m_axis_tdata_o[2:0]),
                        32'(head.res.fmt));
        if (m_axis_tdata_o[8:3] !== head.res.op)
          note_mismatch("operation", head.word, 32'(m_axis_tdata_o[8:3]),
                        32'(head.res.op));
        if (m_axis_tdata_o[13:9] !== head.res.rs1)
          note_mismatch("src1_index", head.word, 32'(m_axis_tdata_o[13:9]),
                        32'(head.res.rs1));
        if (m_axis_tdata_o[18:14] !== head.res.rs2)
          note_mismatch("src2_index", head.word, 32'(m_axis_tdata_o[18:14]),
                        32'(head.res.rs2));
        if (m_axis_tdata_o[23:19] !== head.res.rd)
          note_mismatch("dest_index", head.word, 32'(m_axis_tdata_o[23:19]),
                        32'(head.res.rd));
        if (m_axis_tdata_o[55:24] !== head.res.imm)
          note_mismatch("imm_value", head.word, m_axis_tdata_o[55:24], head.res.imm);
        if (m_axis_tuser_o !== head.res.illegal)
          note_mismatch("illegal", head.word, 32'(m_axis_tuser_o), 32'(head.res.illegal));
      end
    end
  end

  initial begin
    decoded_t    bad;
    decoded_t    none;
    decoded_t    probe;
    logic [31:0] word;
    int unsigned pick;
    bad = make_dec(FMT_R, OP_LUI, '0, '0, '0, '0, 1'b1);
    none = '0;

    // word, expectation typed in?, expectation
    add_row(32'h0000_0000, 1'b1, bad);                                // opcode zero
    add_row(32'hFFFF_FFFF, 1'b1, bad);                                // all ones
    add_row(32'h0000_000B, 1'b1, bad);                                // custom opcode
    add_row(32'hFFFF_FFB7, 1'b1,
            make_dec(FMT_U, OP_LUI, 5'd0, 5'd0, 5'd31, 32'hFFFF_F000, 1'b0));
    add_row(32'h0000_0037, 1'b1, make_dec(FMT_U, OP_LUI, 5'd0, 5'd0, 5'd0, '0, 1'b0));
    add_row(32'h1234_5097, 1'b0, none);
    add_row(32'h8000_006F, 1'b1,
            make_dec(FMT_J, OP_JAL, 5'd0, 5'd0, 5'd0, 32'hFFF0_0000, 1'b0));
    add_row(32'hFFFF_FFEF, 1'b1,
            make_dec(FMT_J, OP_JAL, 5'd0, 5'd0, 5'd31, 32'hFFFF_FFFE, 1'b0));
    add_row(32'h7FF5_F0E7, 1'b0, none);                               // jalr, funct3 ignored
    add_row(32'h0000_3003, 1'b1, bad);                                // load funct3 3
    add_row(32'h7FF0_2083, 1'b0, none);
    add_row(32'h0000_7023, 1'b1, bad);                                // store funct3 7
    add_row(32'hFE00_0FA3, 1'b0, none);
    add_row(32'h0000_2063, 1'b1, bad);                                // branch funct3 2
    add_row(32'h0000_3063, 1'b1, bad);                                // branch funct3 3
    add_row(32'h8000_0063, 1'b1,
            make_dec(FMT_B, OP_BEQ, 5'd0, 5'd0, 5'd0, 32'hFFFF_F000, 1'b0));
    add_row(32'hFFFF_FFE3, 1'b1,
            make_dec(FMT_B, OP_BGEU, 5'd31, 5'd31, 5'd0, 32'hFFFF_FFFE, 1'b0));
    add_row(32'h0020_81B3, 1'b0, none);                               // add
    add_row(32'h4020_81B3, 1'b0, none);                               // sub
    add_row(32'h0220_81B3, 1'b0, none);                               // sub, odd funct7
    add_row(32'h0020_D1B3, 1'b0, none);                               // srl
    add_row(32'h4020_D1B3, 1'b0, none);                               // sra
    add_row(32'h0030_D093, 1'b0, none);                               // srli
    add_row(32'hFE30_D093, 1'b0, none);                               // srai, negative imm
    add_row(32'hFFF0_9093, 1'b0, none);                               // slli, funct7 ignored
    add_row(32'h8000_0013, 1'b1,
            make_dec(FMT_I, OP_ADDI, 5'd0, 5'd0, 5'd0, 32'hFFFF_F800, 1'b0));
    add_row(32'hFFFF_FFB3, 1'b1,
            make_dec(FMT_R, OP_AND, 5'd31, 5'd31, 5'd31, '0, 1'b0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_word[i]) send_word(dir_word[i], dir_typed[i], dir_want[i]);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      calm = (n >= 400 && n < 600);
      pick = $urandom_range(99);
      if (pick < 80) begin
        word = encode_op(op_e'($urandom_range(36)), $urandom());
      end else if (pick < 90) begin
        // recognised opcode, funct3 outside the listed set
        do begin
          word = $urandom();
          case ($urandom_range(2))
            0:       word[6:0] = OPC_LOAD;
            1:       word[6:0] = OPC_STORE;
            default: word[6:0] = OPC_BRANCH;
          endcase
          probe = decode_word(word);
        end while (!probe.illegal);
      end else begin
        word = $urandom();
      end
      send_word(word, 1'b0, none);
    end
    calm = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_rv32i_instruction_decoder passed");
    end else begin
      $display("tb_rv32i_instruction_decoder failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_rv32i_instruction_decoder failed");
    $finish;
  end

endmodule

// ----- rv32i_instruction_decoder.f -----
hw/rtl/rvdec_pkg.sv
hw/rtl/rv32i_instruction_decoder.sv
bench/tb_rv32i_instruction_decoder.sv
